### hw/rtl/itp_pkg.sv
// shared types, character codes and precedence helpers for the infix to postfix converter
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int SYM_W = 8;

  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;  // '^'
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [SYM_W-1:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;  // ')'

  localparam logic [SYM_W-1:0] CH_0 = 8'h30;
  localparam logic [SYM_W-1:0] CH_9 = 8'h39;
  localparam logic [SYM_W-1:0] CH_LA = 8'h61;
  localparam logic [SYM_W-1:0] CH_LZ = 8'h7A;
  localparam logic [SYM_W-1:0] CH_UA = 8'h41;
  localparam logic [SYM_W-1:0] CH_UZ = 8'h5A;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [SYM_W-1:0] wdata;
  } itp_stack_op_t;

  function automatic logic [1:0] prec(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic logic is_operand(input logic [SYM_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/infix_to_postfix_converter_unit.sv
// infix to postfix converter: shunting-yard sequencer around a stack memory
//
// Input channel (in_valid/in_ready): one beat per infix character (kind 0)
// or per end-of-expression mark (kind 1, symbol ignored).
// Output channel (out_valid/out_ready): one beat per result; out_symbol is
// the postfix character when has_symbol is set, expr_done marks the last
// result of an end item, overflow reports a push dropped on a full stack.
// An item is first accepted and then worked on: one work step per popped
// entry, plus a closing step unless it is an end item that finds the
// stack nonempty, whose last pop also closes it. The pop rate of one
// entry per cycle, while the output is not stalled, is set by the single
// read port of the stack memory, whose registered read always holds the
// current top.
// One item is worked on at a time; in_ready is high only between items.
// A stalled receiver holds the output register and freezes the work
// sequence until the beat is taken. Reset empties the stack and drops any
// pending result; stack contents are not cleared.
`default_nettype none
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        kind,
  input  wire [itp_pkg::SYM_W-1:0]   symbol,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [itp_pkg::SYM_W-1:0]  out_symbol,
  output logic                       has_symbol,
  output logic                       expr_done,
  output logic                       overflow
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic             state;
  logic             state_next;
  logic             item_kind;
  logic [SYM_W-1:0] item_sym;

  itp_stack_op_t    st_op;
  logic [SYM_W-1:0] top;
  logic [CW-1:0]    count;

  logic             slot_free;
  logic             emit;
  logic [SYM_W-1:0] e_sym;
  logic             e_has;
  logic             e_done;
  logic             e_ovf;
  logic             empty;
  logic             full;
  logic             pop_cond;

  itp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst   (rst),
    .op    (st_op),
    .top   (top),
    .count (count)
  );

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign empty     = (count == '0);
  assign full      = (count == CW'(STACK_DEPTH));
  // incoming operator yields to the top: higher, or equal and left-assoc
  assign pop_cond  = (prec(top) > prec(item_sym)) ||
                     ((prec(top) == prec(item_sym)) && (item_sym != CH_CARET));

  always_comb begin
    state_next = state;
    st_op      = '0;
    emit       = 1'b0;
    e_sym      = '0;
    e_has      = 1'b0;
    e_done     = 1'b0;
    e_ovf      = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (slot_free) begin
          if (item_kind) begin
            emit = 1'b1;
            if (empty) begin
              e_done     = 1'b1;
              state_next = S_IDLE;
            end else begin
              e_sym     = top;
              e_has     = 1'b1;
              st_op.pop = 1'b1;
              if (count == CW'(1)) begin
                e_done     = 1'b1;
                state_next = S_IDLE;
              end
            end
          end else if (is_operand(item_sym)) begin
            emit       = 1'b1;
            e_sym      = item_sym;
            e_has      = 1'b1;
            state_next = S_IDLE;
          end else if (item_sym == CH_CLOSE) begin
            if (empty) begin
              state_next = S_IDLE;
            end else if (top == CH_OPEN) begin
              st_op.pop  = 1'b1;
              state_next = S_IDLE;
            end else begin
              emit      = 1'b1;
              e_sym     = top;
              e_has     = 1'b1;
              st_op.pop = 1'b1;
            end
          end else if (item_sym != CH_OPEN && !empty && top != CH_OPEN && pop_cond) begin
            emit      = 1'b1;
            e_sym     = top;
            e_has     = 1'b1;
            st_op.pop = 1'b1;
          end else begin
            // push of '(' or of an operator that found nothing to pop
            state_next = S_IDLE;
            if (full) begin
              emit  = 1'b1;
              e_ovf = 1'b1;
            end else begin
              st_op.push  = 1'b1;
              st_op.wdata = item_sym;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_kind <= kind;
      item_sym  <= symbol;
    end
    if (emit) begin
      out_symbol <= e_sym;
      has_symbol <= e_has;
      expr_done  <= e_done;
      overflow   <= e_ovf;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/itp_stack.sv
// operator stack: synchronous memory with a registered top-of-stack read
`default_nettype none
module itp_stack #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  itp_pkg::itp_stack_op_t             op,
  output logic [itp_pkg::SYM_W-1:0]          top,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [SYM_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    top_idx;
  logic [AW-1:0]    raddr;

  always_comb begin
    count_next = count;
    if (op.push) begin
      count_next = count + CW'(1);
    end else if (op.pop) begin
      count_next = count - CW'(1);
    end
    top_idx = count_next - CW'(1);
    raddr   = (count_next == '0) ? '0 : top_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[count[AW-1:0]] <= op.wdata;
    end
  end

  // top always mirrors the entry below count; a push forwards its own data
  always_ff @(posedge clk) begin
    if (op.push) begin
      top <= op.wdata;
    end else begin
      top <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/itp_checker.sv
// port-level checks for the infix to postfix converter, bound to the top level
`default_nettype none
module itp_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [itp_pkg::SYM_W-1:0]   out_symbol,
  input wire                        has_symbol,
  input wire                        expr_done,
  input wire                        overflow
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat left pending after reset");

  // one item in work at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open right after an accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
      $stable(has_symbol) && $stable(expr_done) && $stable(overflow))
    else $error("stalled result beat changed");

  a_empty_beat_flagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_symbol |-> out_symbol == '0 && (expr_done || overflow))
    else $error("result without symbol carries no flag or a stray code");

  a_overflow_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !has_symbol && !expr_done)
    else $error("overflow beat mixed with other content");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_symbol (out_symbol),
  .has_symbol (has_symbol),
  .expr_done  (expr_done),
  .overflow   (overflow)
);
`default_nettype wire
